// ===== hdl/trm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package trm_pkg;
	localparam int AVG_DEPTH = 8;
	localparam int AVG_AW = $clog2(AVG_DEPTH);
	localparam int AVG_CW = $clog2(AVG_DEPTH + 1);
	localparam int HIST_DEPTH = 1024;
	localparam int HIST_AW = $clog2(HIST_DEPTH);
	localparam int HIST_CW = $clog2(HIST_DEPTH + 1);
	localparam int LIMIT_W = 10;
	localparam int DIV_STEPS = 128;
	localparam int DIV_CW = $clog2(DIV_STEPS);
	localparam int SUM_W = 63 + AVG_CW;
	localparam int MS_DIGITS = 4;
	localparam int MS_CW = $clog2(MS_DIGITS);

	localparam logic [62:0] MAX63 = {63{1'b1}};
	localparam logic [63:0] MS_PER_S = 64'd1000;
	localparam logic [26:0] RECIP_1000 = 27'd68719477;
	localparam logic [62:0] SCALE_RESET = 63'd1024;
	localparam logic [62:0] DECADE_TOP = 63'd1000000000000000000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(63);
	localparam logic [11:0] PIX_PER_S = 12'd2;

	typedef enum logic [2:0] {
		DIV_TICK,
		DIV_RATE_D,
		DIV_RATE_U,
		DIV_AVG_D,
		DIV_AVG_U
	} div_sel_t;

	typedef struct packed {
		logic capture;
		logic prime;
		logic div_start;
		div_sel_t start_sel;
		logic div_take;
		div_sel_t take_sel;
		logic walk_start;
		logic scale_start;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic primed;
		logic tdiff_zero;
		logic scroll_zero;
		logic ms_done;
		logic div_done;
		logic walk_done;
		logic scale_done;
		logic slot_free;
	} sts_t;

	function automatic logic [72:0] mul1000(input logic [62:0] x);
		return 73'({x, 10'b0}) - 73'({x, 4'b0}) - 73'({x, 3'b0});
	endfunction
endpackage
`default_nettype wire

// ===== hdl/trm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface trm_in_if;
	logic valid;
	logic ready;
	logic [63:0] tick_ms;
	logic [63:0] total_down;
	logic [63:0] total_up;
	modport source(output valid, tick_ms, total_down, total_up, input ready);
	modport sink(input valid, tick_ms, total_down, total_up, output ready);
endinterface
`default_nettype wire

// ===== hdl/trm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface trm_out_if;
	logic valid;
	logic ready;
	logic [62:0] current_down;
	logic [62:0] current_up;
	logic [62:0] peak_down;
	logic [62:0] peak_up;
	logic [62:0] graph_scale;
	logic [15:0] scroll_pixels;
	modport source(output valid, current_down, current_up, peak_down, peak_up,
		graph_scale, scroll_pixels, input ready);
	modport sink(input valid, current_down, current_up, peak_down, peak_up,
		graph_scale, scroll_pixels, output ready);
endinterface
`default_nettype wire

// ===== hdl/trm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trm_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] dividend,
	input  wire logic [63:0]  divisor,
	output logic              done,
	output logic [62:0]       quot
);
	localparam int DIV_CW_L = trm_pkg::DIV_CW;
	logic [127:0] num_q;
	logic [63:0] den_q, rem_q, quo_q;
	logic sat_q, active_q, done_q;
	logic [DIV_CW_L-1:0] cnt_q;
	logic [64:0] trial;
	logic ge;
	logic [63:0] rem_nx;

	always_comb begin
		trial = {rem_q, num_q[127]};
		ge = trial >= {1'b0, den_q};
		rem_nx = ge ? 64'(trial - {1'b0, den_q}) : trial[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CW_L'(trm_pkg::DIV_STEPS - 1)) begin
				active_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (active_q) begin
			num_q <= {num_q[126:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[62:0], ge};
			sat_q <= sat_q | quo_q[62];
		end
	end

	assign done = done_q;
	assign quot = (sat_q || quo_q[63]) ? trm_pkg::MAX63 : quo_q[62:0];

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !active_q)
		else $error("divider done while running");
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n) start |=> active_q)
		else $error("divider failed to start");
	a_runs_on: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !start && cnt_q != DIV_CW_L'(trm_pkg::DIV_STEPS - 1)) |=> active_q)
		else $error("divider stopped early");
endmodule
`default_nettype wire

// ===== hdl/trm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trm_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire trm_pkg::cmd_t              cmd,
	output trm_pkg::sts_t                   sts,
	input  wire logic                       cfg_wr_en,
	input  wire logic [trm_pkg::LIMIT_W-1:0] cfg_wr_data,
	input  wire logic [63:0]                tick_ms,
	input  wire logic [63:0]                total_down,
	input  wire logic [63:0]                total_up,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [62:0]                     current_down,
	output logic [62:0]                     current_up,
	output logic [62:0]                     peak_down,
	output logic [62:0]                     peak_up,
	output logic [62:0]                     graph_scale,
	output logic [15:0]                     scroll_pixels
);
	localparam int AW = trm_pkg::AVG_AW;
	localparam int CW = trm_pkg::AVG_CW;
	localparam int HW = trm_pkg::HIST_AW;
	localparam int HC = trm_pkg::HIST_CW;
	localparam int SW = trm_pkg::SUM_W;
	localparam int MW = trm_pkg::MS_CW;

	logic primed_q;
	logic [63:0] last_tick_q, last_d_q, last_u_q, cur_tick_q, cur_d_q, cur_u_q;
	logic [9:0] srem_q, prem_q;
	logic [63:0] scroll_q;
	logic [trm_pkg::LIMIT_W-1:0] limit_q;
	logic [62:0] rate_d_q;
	logic [62:0] ring_d [trm_pkg::AVG_DEPTH];
	logic [62:0] ring_u [trm_pkg::AVG_DEPTH];
	logic [AW-1:0] wr_q;
	logic [CW-1:0] rcnt_q, n_q;
	logic [SW-1:0] sum_d_q, sum_u_q;
	logic [62:0] cd_q, cu_q, peak_d_q, peak_u_q, scale_q, mx_q, target_q, p_q;
	logic [1:0] k_q;
	logic [66:0] s11_q;
	logic search_q;
	logic [62:0] mem_d [trm_pkg::HIST_DEPTH];
	logic [62:0] mem_u [trm_pkg::HIST_DEPTH];
	logic [HW-1:0] head_q;
	logic [HC-1:0] hcnt_q, idx_q;
	logic walk_q, rd_v_s1;
	logic [62:0] rd_d_s1, rd_u_s1;
	logic out_v_q;
	logic [62:0] o_cd_q, o_cu_q, o_pd_q, o_pu_q, o_sc_q;
	logic [15:0] o_sp_q;
	logic [63:0] ms_num_q, ms_quo_q;
	logic [9:0] ms_rem_q;
	logic [MW-1:0] ms_cnt_q;
	logic ms_busy_q, ms_done_q;

	logic [63:0] tdiff, dd_raw, ud_raw;
	logic [62:0] dd, ud;
	logic [127:0] div_num;
	logic [63:0] div_den;
	logic [62:0] div_quot;
	logic div_done;
	logic div_go, ms_go;
	logic [25:0] ms_x, ms_sub;
	logic [52:0] ms_prod;
	logic [15:0] ms_dig;
	logic [11:0] part;
	logic [1:0] pdiv;
	logic [11:0] prem_w;
	logic [63:0] scroll_w;
	logic full;
	logic [62:0] old_d, old_u;
	logic [SW-1:0] sum_d_nx, sum_u_nx;
	logic [CW-1:0] n_nx;
	logic [HC-1:0] hcnt_lim;
	logic [HW-1:0] head_nx, rd_addr;
	logic more;
	logic [62:0] mx_nx;
	logic [65:0] cand;
	logic [66:0] cand10;
	logic hit, last_cand;
	logic [64:0] s3;
	logic [62:0] thr, scale_nx;
	logic slot_free;

	always_comb begin
		tdiff = cur_tick_q - last_tick_q;
		dd_raw = (cur_d_q >= last_d_q) ? cur_d_q - last_d_q : '0;
		ud_raw = (cur_u_q >= last_u_q) ? cur_u_q - last_u_q : '0;
		dd = dd_raw[63] ? trm_pkg::MAX63 : dd_raw[62:0];
		ud = ud_raw[63] ? trm_pkg::MAX63 : ud_raw[62:0];
		unique case (cmd.start_sel)
			trm_pkg::DIV_TICK: begin
				div_num = {64'b0, tdiff};
				div_den = trm_pkg::MS_PER_S;
			end
			trm_pkg::DIV_RATE_D: begin
				div_num = {55'b0, trm_pkg::mul1000(dd)};
				div_den = tdiff;
			end
			trm_pkg::DIV_RATE_U: begin
				div_num = {55'b0, trm_pkg::mul1000(ud)};
				div_den = tdiff;
			end
			trm_pkg::DIV_AVG_D: begin
				div_num = 128'(sum_d_q);
				div_den = 64'(n_q);
			end
			trm_pkg::DIV_AVG_U: begin
				div_num = 128'(sum_u_q);
				div_den = 64'(n_q);
			end
			default: begin
				div_num = '0;
				div_den = trm_pkg::MS_PER_S;
			end
		endcase
		div_go = cmd.div_start && cmd.start_sel != trm_pkg::DIV_TICK;
		ms_go = cmd.div_start && cmd.start_sel == trm_pkg::DIV_TICK;
	end

	trm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quot(div_quot)
	);

	always_comb begin
		ms_x = {ms_rem_q, ms_num_q[63:48]};
		ms_prod = {27'b0, ms_x} * {26'b0, trm_pkg::RECIP_1000};
		ms_dig = ms_prod[51:36];
		ms_sub = ms_x - (26'({ms_dig, 10'b0}) - 26'({ms_dig, 4'b0}) - 26'({ms_dig, 3'b0}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_busy_q <= 1'b0;
			ms_done_q <= 1'b0;
			ms_cnt_q <= '0;
		end else if (ms_go) begin
			ms_busy_q <= 1'b1;
			ms_done_q <= 1'b0;
			ms_cnt_q <= '0;
		end else if (ms_busy_q) begin
			ms_cnt_q <= ms_cnt_q + 1'b1;
			if (ms_cnt_q == MW'(trm_pkg::MS_DIGITS - 1)) begin
				ms_busy_q <= 1'b0;
				ms_done_q <= 1'b1;
			end
		end else begin
			ms_done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ms_go) begin
			ms_num_q <= tdiff;
			ms_rem_q <= '0;
			ms_quo_q <= '0;
		end else if (ms_busy_q) begin
			ms_num_q <= {ms_num_q[47:0], 16'b0};
			ms_rem_q <= ms_sub[9:0];
			ms_quo_q <= {ms_quo_q[47:0], ms_dig};
		end
	end

	always_comb begin
		part = 12'(({2'b0, ms_rem_q} + {2'b0, srem_q}) * trm_pkg::PIX_PER_S);
		priority if (part >= 12'd3000) begin
			pdiv = 2'd3;
			prem_w = part - 12'd3000;
		end else if (part >= 12'd2000) begin
			pdiv = 2'd2;
			prem_w = part - 12'd2000;
		end else if (part >= 12'd1000) begin
			pdiv = 2'd1;
			prem_w = part - 12'd1000;
		end else begin
			pdiv = 2'd0;
			prem_w = part;
		end
		scroll_w = 64'({ms_quo_q[62:0], 1'b0}) + 64'(pdiv);
	end

	always_comb begin
		full = rcnt_q == CW'(trm_pkg::AVG_DEPTH);
		old_d = full ? ring_d[wr_q] : '0;
		old_u = full ? ring_u[wr_q] : '0;
		sum_d_nx = sum_d_q + SW'(rate_d_q) - SW'(old_d);
		sum_u_nx = sum_u_q + SW'(div_quot) - SW'(old_u);
		n_nx = full ? rcnt_q : rcnt_q + 1'b1;
		hcnt_lim = (hcnt_q > HC'(limit_q)) ? HC'(limit_q) : hcnt_q;
		head_nx = head_q + 1'b1;
		rd_addr = head_q - idx_q[HW-1:0];
		more = idx_q < hcnt_q;
		mx_nx = mx_q;
		if (rd_d_s1 > mx_nx) mx_nx = rd_d_s1;
		if (rd_u_s1 > mx_nx) mx_nx = rd_u_s1;
	end

	always_comb begin
		unique case (k_q)
			2'd0: cand = 66'(p_q);
			2'd1: cand = 66'({p_q, 1'b0});
			default: cand = 66'({p_q, 2'b0}) + 66'(p_q);
		endcase
		cand10 = 67'({cand, 3'b0}) + 67'({cand, 1'b0});
		hit = cand10 >= s11_q;
		last_cand = (p_q == trm_pkg::DECADE_TOP) && (k_q == 2'd2);
		s3 = 65'({scale_q, 1'b0}) + 65'(scale_q);
		thr = s3[64:2];
		scale_nx = (target_q > scale_q || target_q < thr) ? target_q : scale_q;
		slot_free = !out_v_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			last_tick_q <= '0;
			last_d_q <= '0;
			last_u_q <= '0;
			srem_q <= '0;
			limit_q <= trm_pkg::LIMIT_RESET;
			wr_q <= '0;
			rcnt_q <= '0;
			sum_d_q <= '0;
			sum_u_q <= '0;
			head_q <= '0;
			hcnt_q <= '0;
			peak_d_q <= '0;
			peak_u_q <= '0;
			scale_q <= trm_pkg::SCALE_RESET;
			walk_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			idx_q <= '0;
			search_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			if (cmd.prime) begin
				primed_q <= 1'b1;
				last_tick_q <= cur_tick_q;
				last_d_q <= cur_d_q;
				last_u_q <= cur_u_q;
			end
			if (cmd.div_take && cmd.take_sel == trm_pkg::DIV_RATE_U) begin
				sum_d_q <= sum_d_nx;
				sum_u_q <= sum_u_nx;
				rcnt_q <= n_nx;
				wr_q <= wr_q + 1'b1;
			end
			if (cmd.div_take && cmd.take_sel == trm_pkg::DIV_AVG_U) begin
				head_q <= head_nx;
				hcnt_q <= hcnt_lim + 1'b1;
				if (cd_q > peak_d_q) peak_d_q <= cd_q;
				if (div_quot > peak_u_q) peak_u_q <= div_quot;
			end
			if (cmd.walk_start) begin
				walk_q <= 1'b1;
				idx_q <= '0;
				rd_v_s1 <= 1'b0;
			end else begin
				rd_v_s1 <= walk_q && more;
				if (walk_q) begin
					if (more) idx_q <= idx_q + 1'b1;
					else walk_q <= 1'b0;
				end
			end
			if (cmd.scale_start) search_q <= mx_q != '0;
			else if (search_q && (hit || last_cand)) search_q <= 1'b0;
			if (cmd.commit) begin
				scale_q <= scale_nx;
				srem_q <= prem_q;
				last_tick_q <= cur_tick_q;
				last_d_q <= cur_d_q;
				last_u_q <= cur_u_q;
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_tick_q <= tick_ms;
			cur_d_q <= total_down;
			cur_u_q <= total_up;
		end
		if (cmd.div_take) begin
			unique case (cmd.take_sel)
				trm_pkg::DIV_TICK: begin
					scroll_q <= scroll_w;
					prem_q <= prem_w[9:0];
				end
				trm_pkg::DIV_RATE_D: rate_d_q <= div_quot;
				trm_pkg::DIV_RATE_U: begin
					ring_d[wr_q] <= rate_d_q;
					ring_u[wr_q] <= div_quot;
					n_q <= n_nx;
				end
				trm_pkg::DIV_AVG_D: cd_q <= div_quot;
				trm_pkg::DIV_AVG_U: cu_q <= div_quot;
				default: ;
			endcase
		end
		if (cmd.walk_start) mx_q <= '0;
		else if (rd_v_s1) mx_q <= mx_nx;
		if (cmd.scale_start) begin
			p_q <= 63'd1;
			k_q <= '0;
			s11_q <= 67'({mx_q, 3'b0}) + 67'({mx_q, 1'b0}) + 67'(mx_q);
			target_q <= trm_pkg::SCALE_RESET;
		end else if (search_q) begin
			if (hit) begin
				target_q <= cand[62:0];
			end else if (last_cand) begin
				target_q <= trm_pkg::MAX63;
			end else if (k_q == 2'd2) begin
				k_q <= '0;
				p_q <= 63'({p_q, 3'b0}) + 63'({p_q, 1'b0});
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
		if (cmd.commit) begin
			o_cd_q <= cd_q;
			o_cu_q <= cu_q;
			o_pd_q <= peak_d_q;
			o_pu_q <= peak_u_q;
			o_sc_q <= scale_nx;
			o_sp_q <= (scroll_q[63:16] != '0) ? 16'hFFFF : scroll_q[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_take && cmd.take_sel == trm_pkg::DIV_AVG_U) begin
			mem_d[head_nx] <= cd_q;
			mem_u[head_nx] <= div_quot;
		end
		rd_d_s1 <= mem_d[rd_addr];
		rd_u_s1 <= mem_u[rd_addr];
	end

	always_comb begin
		sts.primed = primed_q;
		sts.tdiff_zero = tdiff == '0;
		sts.scroll_zero = scroll_q == '0;
		sts.ms_done = ms_done_q;
		sts.div_done = div_done;
		sts.walk_done = !walk_q && !rd_v_s1;
		sts.scale_done = !search_q;
		sts.slot_free = slot_free;
	end

	assign out_valid = out_v_q;
	assign current_down = o_cd_q;
	assign current_up = o_cu_q;
	assign peak_down = o_pd_q;
	assign peak_up = o_pu_q;
	assign graph_scale = o_sc_q;
	assign scroll_pixels = o_sp_q;
endmodule
`default_nettype wire

// ===== hdl/trm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire trm_pkg::sts_t sts,
	output trm_pkg::cmd_t      cmd
);
	typedef enum logic [3:0] {
		IDLE, EVAL, DIV_T, SCR, DIV_RD, DIV_RU, AVG0, DIV_AD, DIV_AU, WALK, SCALE, FINISH
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		cmd = '0;
		cmd.start_sel = trm_pkg::DIV_TICK;
		cmd.take_sel = trm_pkg::DIV_TICK;
		state_nx = state_q;
		unique case (state_q)
			IDLE: if (in_valid) begin
				cmd.capture = 1'b1;
				state_nx = EVAL;
			end
			EVAL: begin
				priority if (!sts.primed) begin
					cmd.prime = 1'b1;
					state_nx = IDLE;
				end else if (sts.tdiff_zero) begin
					state_nx = IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_nx = DIV_T;
				end
			end
			DIV_T: if (sts.ms_done) begin
				cmd.div_take = 1'b1;
				state_nx = SCR;
			end
			SCR: begin
				if (sts.scroll_zero) begin
					state_nx = IDLE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.start_sel = trm_pkg::DIV_RATE_D;
					state_nx = DIV_RD;
				end
			end
			DIV_RD: if (sts.div_done) begin
				cmd.div_take = 1'b1;
				cmd.take_sel = trm_pkg::DIV_RATE_D;
				cmd.div_start = 1'b1;
				cmd.start_sel = trm_pkg::DIV_RATE_U;
				state_nx = DIV_RU;
			end
			DIV_RU: if (sts.div_done) begin
				cmd.div_take = 1'b1;
				cmd.take_sel = trm_pkg::DIV_RATE_U;
				state_nx = AVG0;
			end
			AVG0: begin
				cmd.div_start = 1'b1;
				cmd.start_sel = trm_pkg::DIV_AVG_D;
				state_nx = DIV_AD;
			end
			DIV_AD: if (sts.div_done) begin
				cmd.div_take = 1'b1;
				cmd.take_sel = trm_pkg::DIV_AVG_D;
				cmd.div_start = 1'b1;
				cmd.start_sel = trm_pkg::DIV_AVG_U;
				state_nx = DIV_AU;
			end
			DIV_AU: if (sts.div_done) begin
				cmd.div_take = 1'b1;
				cmd.take_sel = trm_pkg::DIV_AVG_U;
				cmd.walk_start = 1'b1;
				state_nx = WALK;
			end
			WALK: if (sts.walk_done) begin
				cmd.scale_start = 1'b1;
				state_nx = SCALE;
			end
			SCALE: if (sts.scale_done) state_nx = FINISH;
			FINISH: if (sts.slot_free) begin
				cmd.commit = 1'b1;
				state_nx = IDLE;
			end
			default: state_nx = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= IDLE;
		else state_q <= state_nx;
	end

	assign in_ready = state_q == IDLE;
endmodule
`default_nettype wire

// ===== hdl/traffic_rate_meter_autoscale.sv =====
// Steps to the output register: a 4-step split of elapsed time into seconds, four passes
// of the 128-step divider (two rates, two averages), a walk of the kept history entries
// one per cycle for their maximum, then the 1-2-5 scale search.
// Throughput: one transfer at a time; the next is taken once the result is in the output
// register. Priming and zero-elapsed transfers end before the split, no-scroll ones after.
// Reset: asynchronous, clears control state, scale to 1024, history limit to 63.
`timescale 1ns / 1ps
`default_nettype none
module traffic_rate_meter_autoscale (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	trm_in_if.sink                           sample,
	trm_out_if.source                        report,
	input  wire logic                        cfg_wr_en,
	input  wire logic [trm_pkg::LIMIT_W-1:0] cfg_wr_data
);
	trm_pkg::cmd_t cmd;
	trm_pkg::sts_t sts;

	trm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(sample.valid), .in_ready(sample.ready),
		.sts(sts), .cmd(cmd)
	);

	trm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.tick_ms(sample.tick_ms), .total_down(sample.total_down), .total_up(sample.total_up),
		.out_valid(report.valid), .out_ready(report.ready),
		.current_down(report.current_down), .current_up(report.current_up),
		.peak_down(report.peak_down), .peak_up(report.peak_up),
		.graph_scale(report.graph_scale), .scroll_pixels(report.scroll_pixels)
	);
endmodule
`default_nettype wire

// ===== bench/traffic_rate_meter_autoscale_tb.sv =====
`timescale 1ns / 1ps
module traffic_rate_meter_autoscale_tb;
	localparam int LW = trm_pkg::LIMIT_W;
	localparam int AVG_DEPTH = trm_pkg::AVG_DEPTH;
	localparam int HIST_DEPTH = trm_pkg::HIST_DEPTH;

	typedef struct {
		logic [63:0] tick;
		logic [63:0] down;
		logic [63:0] up;
	} sample_t;

	typedef struct {
		logic [62:0] cur_down;
		logic [62:0] cur_up;
		logic [62:0] pk_down;
		logic [62:0] pk_up;
		logic [62:0] scale;
		logic [15:0] scroll;
	} report_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [LW-1:0] cfg_wr_data;

	trm_in_if sample_if();
	trm_out_if report_if();

	traffic_rate_meter_autoscale u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_if.sink),
		.report(report_if.source),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	sample_t pending_samples[$];
	report_t expected_reports[$];
	int errors;
	bit quiet;
	int reports_seen;

	// meter state mirror
	logic [LW-1:0] hist_limit;
	bit m_primed;
	logic [63:0] m_tick, m_down, m_up, m_rem;
	logic [62:0] down_ring[AVG_DEPTH];
	logic [62:0] up_ring[AVG_DEPTH];
	int ring_cnt, ring_wr;
	logic [62:0] down_hist[HIST_DEPTH];
	logic [62:0] up_hist[HIST_DEPTH];
	int hist_cnt, hist_head;
	logic [62:0] m_pk_down, m_pk_up, m_scale;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [62:0] bytes_per_s(input logic [63:0] bytes, input logic [63:0] ms);
		logic [127:0] q;
		q = ({64'b0, bytes} * 128'd1000) / {64'b0, ms};
		return (q > {65'b0, trm_pkg::MAX63}) ? trm_pkg::MAX63 : q[62:0];
	endfunction

	function automatic logic [62:0] ring_mean(input logic [62:0] ring[AVG_DEPTH], input int n);
		logic [127:0] acc;
		acc = 0;
		for (int i = 0; i < n; i++)
			acc += {65'b0, ring[i]};
		acc = acc / n;
		return acc[62:0];
	endfunction

	function automatic logic [62:0] scale_125(input logic [62:0] speed);
		logic [127:0] target, p, c;
		int mult[3];
		mult = '{1, 2, 5};
		if (speed == 0)
			return trm_pkg::SCALE_RESET;
		target = ({65'b0, speed} * 11 + 9) / 10;
		p = 1;
		forever begin
			for (int k = 0; k < 3; k++) begin
				c = p * mult[k];
				if (c > {65'b0, trm_pkg::MAX63})
					return trm_pkg::MAX63;
				if (c >= target)
					return c[62:0];
			end
			p = p * 10;
		end
	endfunction

	task automatic predict_report(input sample_t s);
		logic [63:0] tdiff, part, scroll, dd, ud;
		logic [62:0] cd, cu, mx, target;
		logic [127:0] thr;
		int n, lim, idx;
		report_t r;
		if (!m_primed) begin
			m_primed = 1;
			m_tick = s.tick;
			m_down = s.down;
			m_up = s.up;
			return;
		end
		tdiff = s.tick - m_tick;
		if (tdiff == 0)
			return;
		part = (tdiff % 1000 + m_rem) * 2;
		scroll = (tdiff / 1000) * 2 + part / 1000;
		if (scroll == 0)
			return;
		m_rem = part % 1000;
		dd = (s.down >= m_down) ? s.down - m_down : 64'd0;
		ud = (s.up >= m_up) ? s.up - m_up : 64'd0;
		if (dd > {1'b0, trm_pkg::MAX63}) dd = {1'b0, trm_pkg::MAX63};
		if (ud > {1'b0, trm_pkg::MAX63}) ud = {1'b0, trm_pkg::MAX63};
		n = (ring_cnt < AVG_DEPTH) ? ring_cnt + 1 : AVG_DEPTH;
		down_ring[ring_wr] = bytes_per_s(dd, tdiff);
		up_ring[ring_wr] = bytes_per_s(ud, tdiff);
		cd = ring_mean(down_ring, n);
		cu = ring_mean(up_ring, n);
		ring_wr = (ring_wr + 1) % AVG_DEPTH;
		if (ring_cnt < AVG_DEPTH) ring_cnt++;
		lim = (hist_limit < HIST_DEPTH - 1) ? int'(hist_limit) : HIST_DEPTH - 1;
		if (hist_cnt > lim) hist_cnt = lim;
		hist_head = (hist_head + 1) % HIST_DEPTH;
		down_hist[hist_head] = cd;
		up_hist[hist_head] = cu;
		hist_cnt++;
		if (cd > m_pk_down) m_pk_down = cd;
		if (cu > m_pk_up) m_pk_up = cu;
		mx = 0;
		for (int i = 0; i < hist_cnt; i++) begin
			idx = (hist_head + HIST_DEPTH - i) % HIST_DEPTH;
			if (down_hist[idx] > mx) mx = down_hist[idx];
			if (up_hist[idx] > mx) mx = up_hist[idx];
		end
		target = scale_125(mx);
		thr = ({65'b0, m_scale} * 3) / 4;
		if (target > m_scale || {65'b0, target} < thr)
			m_scale = target;
		m_tick = s.tick;
		m_down = s.down;
		m_up = s.up;
		r.cur_down = cd;
		r.cur_up = cu;
		r.pk_down = m_pk_down;
		r.pk_up = m_pk_up;
		r.scale = m_scale;
		r.scroll = (scroll > 64'd65535) ? 16'hFFFF : scroll[15:0];
		expected_reports = {expected_reports, r};
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// sender
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		bit xfer;
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
			send_gap <= 0;
		end else begin
			xfer = sample_if.valid && sample_if.ready;
			if (xfer) begin
				s.tick = sample_if.tick_ms;
				s.down = sample_if.total_down;
				s.up = sample_if.total_up;
				predict_report(s);
			end
			if (sample_if.valid && !xfer) begin
				sample_if.valid <= 1'b1;
			end else if (xfer && pick_gap() > 0) begin
				send_gap <= pick_gap();
				sample_if.valid <= 1'b0;
			end else if (!xfer && send_gap > 0) begin
				send_gap <= send_gap - 1;
				sample_if.valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				s = pending_samples.pop_front();
				sample_if.tick_ms <= s.tick;
				sample_if.total_down <= s.down;
				sample_if.total_up <= s.up;
				sample_if.valid <= 1'b1;
			end else begin
				sample_if.valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	int hold_left;
	bit long_hold_done;
	always @(posedge clk or negedge arst_n) begin
		report_t e;
		if (!arst_n) begin
			report_if.ready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 0;
			reports_seen <= 0;
		end else begin
			if (report_if.valid && report_if.ready) begin
				reports_seen <= reports_seen + 1;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report, actual down %0d up %0d", $time,
						report_if.current_down, report_if.current_up);
					errors++;
				end else begin
					e = expected_reports.pop_front();
					if (report_if.current_down !== e.cur_down) begin
						$display("%0t: current_down expected %0d actual %0d", $time,
							e.cur_down, report_if.current_down);
						errors++;
					end
					if (report_if.current_up !== e.cur_up) begin
						$display("%0t: current_up expected %0d actual %0d", $time,
							e.cur_up, report_if.current_up);
						errors++;
					end
					if (report_if.peak_down !== e.pk_down) begin
						$display("%0t: peak_down expected %0d actual %0d", $time,
							e.pk_down, report_if.peak_down);
						errors++;
					end
					if (report_if.peak_up !== e.pk_up) begin
						$display("%0t: peak_up expected %0d actual %0d", $time,
							e.pk_up, report_if.peak_up);
						errors++;
					end
					if (report_if.graph_scale !== e.scale) begin
						$display("%0t: graph_scale expected %0d actual %0d", $time,
							e.scale, report_if.graph_scale);
						errors++;
					end
					if (report_if.scroll_pixels !== e.scroll) begin
						$display("%0t: scroll_pixels expected %0d actual %0d", $time,
							e.scroll, report_if.scroll_pixels);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				report_if.ready <= 1'b0;
			end else if (!long_hold_done && reports_seen == 30) begin
				long_hold_done <= 1;
				hold_left <= 6000;
				report_if.ready <= 1'b0;
			end else if (quiet) begin
				report_if.ready <= 1'b1;
			end else begin
				report_if.ready <= ($urandom_range(0, 99) < 70) ||
					($urandom_range(0, 9) == 0 && 1'b0);
			end
		end
	end

	int unsigned cycles;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic settle();
		wait (pending_samples.size() == 0 && !sample_if.valid &&
			expected_reports.size() == 0);
		repeat (1800) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LW-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hist_limit = v;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	logic [63:0] run_tick, run_down, run_up;

	task automatic add(input logic [63:0] t, input logic [63:0] d, input logic [63:0] u);
		sample_t s;
		s.tick = t;
		s.down = d;
		s.up = u;
		pending_samples = {pending_samples, s};
		run_tick = t;
		run_down = d;
		run_up = u;
	endtask

	task automatic add_random(input int count);
		int r;
		logic [63:0] dt;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				add(rand64(), rand64(), rand64());
			end else if (r < 12) begin
				add(run_tick + $urandom_range(1, 400), run_down, run_up);
			end else begin
				dt = (r < 16) ? rand64() >> $urandom_range(0, 63) : $urandom_range(500, 4000);
				add(run_tick + dt, run_down + (rand64() >> $urandom_range(1, 63)),
					(r < 20) ? run_up - $urandom_range(1, 1000) :
					run_up + (rand64() >> $urandom_range(1, 63)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		sample_if.valid = 1'b0;
		sample_if.tick_ms = '0;
		sample_if.total_down = '0;
		sample_if.total_up = '0;
		report_if.ready = 1'b0;
		errors = 0;
		cycles = 0;
		quiet = 0;
		hist_limit = trm_pkg::LIMIT_RESET;
		m_primed = 0;
		m_tick = 0;
		m_down = 0;
		m_up = 0;
		m_rem = 0;
		ring_cnt = 0;
		ring_wr = 0;
		hist_cnt = 0;
		hist_head = 0;
		m_pk_down = 0;
		m_pk_up = 0;
		m_scale = trm_pkg::SCALE_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		write_limit(10'd63);
		add(64'd1000, 64'd0, 64'd0);
		add(64'd1000, 64'd5, 64'd5);
		add(64'd1100, 64'd10, 64'd10);
		add(64'd1600, 64'd1000, 64'd0);
		add(64'd2600, 64'd0, 64'd500);
		add(64'd3100, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add(64'd5100, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add(64'hFFFF_FFFF_FFFF_FED4, 64'd0, 64'd0);
		add(64'd700, 64'd12345, 64'd999);
		add(64'd701, 64'd12346, 64'd1000);
		add(64'd2200, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
		add(64'd4200, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
		settle();

		write_limit(10'd0);
		add(run_tick + 1000, run_down, run_up);
		add(run_tick + 1000, run_down, run_up);
		add(run_tick + 3000, run_down + 50, run_up + 7);
		add_random(40);
		settle();

		write_limit(10'd1023);
		add_random(60);
		settle();

		write_limit(10'd1);
		add_random(40);
		settle();

		quiet = 1;
		write_limit(LW'($urandom_range(2, 1022)));
		add_random(60);
		settle();
		quiet = 0;

		write_limit(10'd5);
		add_random(60);
		settle();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
